@@ hw/rtl/spr_pkg.sv @@
`default_nettype none

package spr_pkg;

  localparam int unsigned PatMax  = 16;
  localparam int unsigned RepMax  = 16;
  localparam int unsigned LenW    = 5;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDW   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAT_LO  = 3'd0,
    REG_PAT_HI  = 3'd1,
    REG_REP_LO  = 3'd2,
    REG_REP_HI  = 3'd3,
    REG_PAT_LEN = 3'd4,
    REG_REP_LEN = 3'd5
  } spr_reg_e;

  typedef struct packed {
    logic [PatMax*8-1:0] pat;
    logic [RepMax*8-1:0] rep;
    logic [LenW-1:0]     pat_len;
    logic [LenW-1:0]     rep_len;
  } spr_cfg_t;

  typedef enum logic [8:0] {
    ST_IDLE       = 9'b000000001,
    ST_BUILD_INIT = 9'b000000010,
    ST_BUILD_CHK  = 9'b000000100,
    ST_BUILD_WAIT = 9'b000001000,
    ST_SCAN       = 9'b000010000,
    ST_FALL_WAIT  = 9'b000100000,
    ST_DROP       = 9'b001000000,
    ST_REPL       = 9'b010000000,
    ST_FLUSH      = 9'b100000000
  } spr_state_e;

  function automatic logic [7:0] byte_at(input logic [PatMax*8-1:0] vec,
                                         input logic [IdxW-1:0] idx);
    byte_at = vec[idx*8 +: 8];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/spr_ram.sv @@
`default_nettype none

module spr_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/spr_cfg.sv @@
`default_nettype none

module spr_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            we_i,
  input  wire logic [spr_pkg::CfgIdxW-1:0]     idx_i,
  input  wire logic [spr_pkg::CfgDW-1:0]       data_i,
  output spr_pkg::spr_cfg_t                    cfg_o,
  output logic                                 rebuild_o
);
  import spr_pkg::*;

  logic [CfgDW-1:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [LenW-1:0]  pat_len_q, rep_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      rep_lo_q  <= '0;
      rep_hi_q  <= '0;
      pat_len_q <= LenW'(1);
      rep_len_q <= '0;
    end else if (we_i) begin
      case (idx_i)
        REG_PAT_LO:  pat_lo_q  <= data_i;
        REG_PAT_HI:  pat_hi_q  <= data_i;
        REG_REP_LO:  rep_lo_q  <= data_i;
        REG_REP_HI:  rep_hi_q  <= data_i;
        REG_PAT_LEN: pat_len_q <= data_i[LenW-1:0];
        REG_REP_LEN: rep_len_q <= data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // pattern writes invalidate the failure table
  always_comb begin
    rebuild_o = 1'b0;
    if (we_i) begin
      case (idx_i)
        REG_PAT_LO, REG_PAT_HI, REG_PAT_LEN: rebuild_o = 1'b1;
        default: rebuild_o = 1'b0;
      endcase
    end
  end

  always_comb begin
    cfg_o.pat = {pat_hi_q, pat_lo_q};
    cfg_o.rep = {rep_hi_q, rep_lo_q};
    if (pat_len_q == '0) begin
      cfg_o.pat_len = LenW'(1);
    end else if (pat_len_q > LenW'(PatMax)) begin
      cfg_o.pat_len = LenW'(PatMax);
    end else begin
      cfg_o.pat_len = pat_len_q;
    end
    if (rep_len_q > LenW'(RepMax)) begin
      cfg_o.rep_len = LenW'(RepMax);
    end else begin
      cfg_o.rep_len = rep_len_q;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stream_pattern_replacer.sv @@
`default_nettype none
// channel | signals                                        | direction
// input   | in_valid_i, in_stall_o, data_byte_i, stream_end_i | source -> block
// output  | out_valid_o, out_stall_i, out_byte_o, byte_valid_o,
//         | run_last_o, stream_done_o                         | block -> sink
// config  | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | host -> block
//
// one byte at a time: the byte is accepted in idle, scanned, and closed in the
// flush state, with a failure table read and a drop state per kmp fallback, and
// replacement, dropped and flushed bytes are emitted one at a time
// after reset and after each pattern write the failure table is rebuilt in
// the table ram, input stalled
// the last result of a transaction is held one step back so run_last is known
// a full output register only stalls the sequencer when it must push
// an input transaction offered in idle goes ahead of a config write

module stream_pattern_replacer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic                        stream_end_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [7:0]                  out_byte_o,
  output logic                             byte_valid_o,
  output logic                             run_last_o,
  output logic                             stream_done_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [spr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [spr_pkg::CfgDW-1:0]   cfg_data_i
);
  import spr_pkg::*;

  spr_cfg_t cfg;
  logic     rebuild;
  logic     cfg_we;

  spr_state_e st_q, st_d;
  logic [LenW-1:0] k_q, k_d;      // partial match length, also k during build
  logic [LenW-1:0] q_q, q_d;      // build position
  logic [LenW-1:0] nk_q, nk_d;    // fallback target
  logic [LenW-1:0] cnt_q, cnt_d;  // emit counter
  logic [7:0]      b_q, b_d;
  logic            end_q, end_d;
  logic            pend_v_q, pend_v_d;
  logic [7:0]      pend_b_q, pend_b_d;
  logic            ov_q, ov_d;
  logic [7:0]      ob_q, ob_d;
  logic            obv_q, obv_d, olast_q, olast_d, odone_q, odone_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [LenW-1:0] ram_wdata, ram_rdata;

  logic            out_free;
  logic            emit_req;
  logic [7:0]      emit_b;
  logic            can_emit;
  logic [LenW-1:0] k_in;
  logic [7:0]      pk, pq;

  assign cfg_ready_o = (st_q == ST_IDLE) && !in_valid_i;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (st_q != ST_IDLE);

  spr_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (cfg_we),
    .idx_i     (cfg_index_i),
    .data_i    (cfg_data_i),
    .cfg_o     (cfg),
    .rebuild_o (rebuild)
  );

  spr_ram #(.Width(LenW), .Depth(PatMax)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register frees when empty or taken this cycle
  assign out_free = !ov_q || !out_stall_i;
  // a new result moves the held one to the output register
  assign can_emit = !pend_v_q || out_free;

  assign pk = byte_at(cfg.pat, k_q[IdxW-1:0]);
  assign pq = byte_at(cfg.pat, q_q[IdxW-1:0]);

  always_comb begin
    st_d     = st_q;
    k_d      = k_q;
    q_d      = q_q;
    nk_d     = nk_q;
    cnt_d    = cnt_q;
    b_d      = b_q;
    end_d    = end_q;
    pend_v_d = pend_v_q;
    pend_b_d = pend_b_q;
    ov_d     = ov_q && out_stall_i;
    ob_d     = ob_q;
    obv_d    = obv_q;
    olast_d  = olast_q;
    odone_d  = odone_q;
    ram_we    = 1'b0;
    ram_waddr = q_q[IdxW-1:0];
    ram_wdata = '0;
    ram_raddr = k_q[IdxW-1:0] - IdxW'(1);
    emit_req  = 1'b0;
    emit_b    = b_q;
    k_in      = (k_q >= cfg.pat_len) ? '0 : k_q;

    case (st_q)
      ST_IDLE: begin
        if (cfg_we && rebuild) begin
          st_d = ST_BUILD_INIT;
        end else if (in_valid_i) begin
          b_d   = data_byte_i;
          end_d = stream_end_i;
          k_d   = k_in;
          st_d  = ST_SCAN;
        end
      end
      ST_BUILD_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
        k_d       = '0;
        q_d       = LenW'(1);
        st_d      = ST_BUILD_CHK;
      end
      ST_BUILD_CHK: begin
        if (q_q >= cfg.pat_len) begin
          k_d  = '0;
          st_d = ST_IDLE;
        end else if (k_q != '0 && pk != pq) begin
          st_d = ST_BUILD_WAIT;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = k_q + ((pk == pq) ? LenW'(1) : LenW'(0));
          k_d       = ram_wdata;
          q_d       = q_q + LenW'(1);
        end
      end
      ST_BUILD_WAIT: begin
        k_d  = ram_rdata;
        st_d = ST_BUILD_CHK;
      end
      ST_SCAN: begin
        if (k_q != '0 && pk != b_q) begin
          st_d = ST_FALL_WAIT;
        end else if (pk == b_q) begin
          if (k_q + LenW'(1) == cfg.pat_len) begin
            k_d   = '0;
            cnt_d = '0;
            st_d  = (cfg.rep_len != '0) ? ST_REPL : ST_FLUSH;
          end else begin
            k_d   = k_q + LenW'(1);
            cnt_d = '0;
            st_d  = ST_FLUSH;
          end
        end else begin
          emit_req = 1'b1;
          emit_b   = b_q;
          if (can_emit) begin
            k_d   = '0;
            cnt_d = '0;
            st_d  = ST_FLUSH;
          end
        end
      end
      ST_FALL_WAIT: begin
        nk_d  = ram_rdata;
        cnt_d = '0;
        st_d  = ST_DROP;
      end
      ST_DROP: begin
        // bytes that fall out of the partial match come from the pattern prefix
        emit_req = 1'b1;
        emit_b   = byte_at(cfg.pat, cnt_q[IdxW-1:0]);
        if (can_emit) begin
          if (cnt_q + LenW'(1) == k_q - nk_q) begin
            k_d  = nk_q;
            st_d = ST_SCAN;
          end else begin
            cnt_d = cnt_q + LenW'(1);
          end
        end
      end
      ST_REPL: begin
        emit_req = 1'b1;
        emit_b   = byte_at(cfg.rep, cnt_q[IdxW-1:0]);
        if (can_emit) begin
          if (cnt_q + LenW'(1) == cfg.rep_len) begin
            cnt_d = '0;
            st_d  = ST_FLUSH;
          end else begin
            cnt_d = cnt_q + LenW'(1);
          end
        end
      end
      ST_FLUSH: begin
        // stream end flushes the held prefix, then the held result goes out last
        if (end_q && cnt_q < k_q) begin
          emit_req = 1'b1;
          emit_b   = byte_at(cfg.pat, cnt_q[IdxW-1:0]);
          if (can_emit) begin
            cnt_d = cnt_q + LenW'(1);
          end
        end else if (pend_v_q || end_q) begin
          if (out_free) begin
            ov_d     = 1'b1;
            ob_d     = pend_v_q ? pend_b_q : 8'd0;
            obv_d    = pend_v_q;
            olast_d  = 1'b1;
            odone_d  = end_q;
            pend_v_d = 1'b0;
            if (end_q) begin
              k_d = '0;
            end
            st_d = ST_IDLE;
          end
        end else begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (emit_req && can_emit) begin
      if (pend_v_q) begin
        ov_d    = 1'b1;
        ob_d    = pend_b_q;
        obv_d   = 1'b1;
        olast_d = 1'b0;
        odone_d = 1'b0;
      end
      pend_v_d = 1'b1;
      pend_b_d = emit_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_BUILD_INIT;
      k_q      <= '0;
      q_q      <= '0;
      nk_q     <= '0;
      cnt_q    <= '0;
      end_q    <= 1'b0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      k_q      <= k_d;
      q_q      <= q_d;
      nk_q     <= nk_d;
      cnt_q    <= cnt_d;
      end_q    <= end_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q      <= b_d;
    pend_b_q <= pend_b_d;
    ob_q     <= ob_d;
    obv_q    <= obv_d;
    olast_q  <= olast_d;
    odone_q  <= odone_d;
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = ob_q;
  assign byte_valid_o  = obv_q;
  assign run_last_o    = olast_q;
  assign stream_done_o = odone_q;

`ifndef SYNTHESIS
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_SCAN |-> k_q < cfg.pat_len)
    else $error("match length out of range in scan");
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_IDLE |-> !pend_v_q)
    else $error("held result left over in idle");
  a_drop_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_DROP |-> nk_q < k_q)
    else $error("fallback does not shorten the match");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !pend_v_q && !in_stall_o)
    else $error("config accepted while busy");
`endif

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import spr_pkg::*;

  typedef struct {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_done;
  } replace_result_t;

  // predicts the byte stream after search and replace and checks the results
  class replace_scoreboard;
    logic [7:0]      pat[PatMax];
    logic [7:0]      rep[RepMax];
    logic [63:0]     reg_val[6];
    int unsigned     pat_len, rep_len, match_len;
    int unsigned     border[PatMax];
    replace_result_t expected_q[$];
    replace_result_t item_q[$];
    int unsigned     errors, items_seen, results_seen;

    function void reset_state();
      foreach (reg_val[i]) reg_val[i] = '0;
      reg_val[REG_PAT_LEN] = 1;
      match_len = 0;
      reload();
    endfunction

    function void reload();
      int unsigned k;
      pat_len = reg_val[REG_PAT_LEN][4:0];
      if (pat_len == 0) pat_len = 1;
      if (pat_len > PatMax) pat_len = PatMax;
      rep_len = reg_val[REG_REP_LEN][4:0];
      if (rep_len > RepMax) rep_len = RepMax;
      for (int i = 0; i < 8; i++) begin
        pat[i]     = reg_val[REG_PAT_LO][8*i +: 8];
        pat[i + 8] = reg_val[REG_PAT_HI][8*i +: 8];
        rep[i]     = reg_val[REG_REP_LO][8*i +: 8];
        rep[i + 8] = reg_val[REG_REP_HI][8*i +: 8];
      end
      // kmp border table
      border[0] = 0;
      k = 0;
      for (int q = 1; q < pat_len; q++) begin
        while (k > 0 && pat[k] != pat[q]) k = border[k - 1];
        if (pat[k] == pat[q]) k++;
        border[q] = k;
      end
    endfunction

    function void write_reg(spr_reg_e idx, logic [63:0] value);
      reg_val[idx] = value;
      if (idx == REG_PAT_LO || idx == REG_PAT_HI || idx == REG_PAT_LEN) match_len = 0;
      reload();
    endfunction

    function void push_byte(logic [7:0] b, logic valid);
      replace_result_t r;
      if (item_q.size() < 16) begin
        r.out_byte    = valid ? b : 8'h00;
        r.byte_valid  = valid;
        r.run_last    = 1'b0;
        r.stream_done = 1'b0;
        item_q.push_back(r);
      end
    endfunction

    function void note_input(logic [7:0] b, logic fin);
      int unsigned k, nk;
      items_seen++;
      item_q.delete();
      k = match_len;
      if (k >= pat_len) k = 0;
      while (k > 0 && pat[k] != b) begin
        nk = border[k - 1];
        for (int i = 0; i < k - nk; i++) push_byte(pat[i], 1'b1);
        k = nk;
      end
      if (pat[k] == b) begin
        k++;
        if (k >= pat_len) begin
          for (int i = 0; i < rep_len; i++) push_byte(rep[i], 1'b1);
          k = 0;
        end
      end else begin
        push_byte(b, 1'b1);
      end
      if (fin) begin
        for (int i = 0; i < k; i++) push_byte(pat[i], 1'b1);
        k = 0;
        if (item_q.size() == 0) push_byte(8'h00, 1'b0);
        item_q[item_q.size() - 1].stream_done = 1'b1;
      end
      match_len = k;
      if (item_q.size() > 0) item_q[item_q.size() - 1].run_last = 1'b1;
      foreach (item_q[i]) expected_q.push_back(item_q[i]);
    endfunction

    function void check_result(replace_result_t got);
      replace_result_t exp_r;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_byte %h byte_valid %b", got.out_byte, got.byte_valid);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.out_byte !== exp_r.out_byte) begin
        $error("out_byte: expected %h actual %h", exp_r.out_byte, got.out_byte);
        errors++;
      end
      if (got.byte_valid !== exp_r.byte_valid) begin
        $error("byte_valid: expected %b actual %b", exp_r.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.run_last !== exp_r.run_last) begin
        $error("run_last: expected %b actual %b", exp_r.run_last, got.run_last);
        errors++;
      end
      if (got.stream_done !== exp_r.stream_done) begin
        $error("stream_done: expected %b actual %b", exp_r.stream_done, got.stream_done);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned CycleLimit = 400000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       data_byte_i = '0;
  logic             stream_end_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       out_byte_o;
  logic             byte_valid_o;
  logic             run_last_o;
  logic             stream_done_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDW-1:0] cfg_data_i = '0;

  replace_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned phase_count = 0;
  bit          sink_quiet = 1'b0;

  always #6 clk_i = ~clk_i;

  stream_pattern_replacer dut (.*);

  // transaction monitors, sampled at the edge with pre-edge values
  always @(posedge clk_i) begin
    replace_result_t got;
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(data_byte_i, stream_end_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.out_byte    = out_byte_o;
      got.byte_valid  = byte_valid_o;
      got.run_last    = run_last_o;
      got.stream_done = stream_done_o;
      sb.check_result(got);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // sink backpressure: mostly short stalls, a few long ones, some quiet stretches
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) sink_quiet <= ~sink_quiet;
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!sink_quiet && $urandom_range(0, 99) < 15) begin
      stall_left  <= $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else if (!sink_quiet && $urandom_range(0, 99) < 2) begin
      stall_left  <= $urandom_range(10, 40);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // one input transaction, then a random gap
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned roll, gap;
    roll = $urandom_range(0, 99);
    if (roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 2);
    else if (roll < 98) gap = $urandom_range(3, 6);
    else gap = $urandom_range(10, 30);
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    stream_end_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait until every expected result is out, then let a byte still in flight settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(input spr_reg_e idx, input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // full reprogram; length registers carry random junk above bit 4
  task automatic program_regs(input logic [7:0] p[PatMax], input int unsigned plen,
                              input logic [7:0] r[RepMax], input int unsigned rlen);
    logic [127:0] pv, rv;
    for (int i = 0; i < 16; i++) begin
      pv[8*i +: 8] = p[i];
      rv[8*i +: 8] = r[i];
    end
    drain();
    phase_count++;
    write_reg(REG_PAT_LO, pv[63:0]);
    write_reg(REG_PAT_HI, pv[127:64]);
    write_reg(REG_REP_LO, rv[63:0]);
    write_reg(REG_REP_HI, rv[127:64]);
    write_reg(REG_PAT_LEN, {$urandom(), 27'($urandom()), 5'(plen)});
    write_reg(REG_REP_LEN, {$urandom(), 27'($urandom()), 5'(rlen)});
  endtask

  initial begin
    logic [7:0]  p[PatMax];
    logic [7:0]  r[RepMax];
    logic [7:0]  alpha[3];
    int unsigned plen, rlen, n;
    logic [7:0]  b;

    sb.reset_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: single zero byte pattern, empty replacement deletes it
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);  // match at stream end gives a bare end marker

    // self-overlapping pattern exercises fallback and drop of held bytes
    foreach (p[i]) p[i] = 8'h00;
    foreach (r[i]) r[i] = 8'($urandom());
    p[1] = 8'hFF; p[3] = 8'hFF; p[4] = 8'h01;
    r[0] = 8'hA5;
    program_regs(p, 5, r, 1);
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);  // match after one fallback
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h7E, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b1);  // flush pending prefix

    // zero pattern length acts as one, oversized replacement length saturates
    program_regs(p, 0, r, 31);
    send_byte(8'h00, 1'b0);  // sixteen replacement bytes
    send_byte(8'h00, 1'b1);

    // oversized pattern length saturates to the full sixteen bytes
    foreach (p[i]) p[i] = 8'($urandom());
    program_regs(p, 31, r, 0);
    for (int i = 0; i < 16; i++) send_byte(p[i], i == 15);

    // random phases over small alphabets so matches and partial matches are common
    for (int ph = 0; ph < 6; ph++) begin
      foreach (alpha[i]) alpha[i] = 8'($urandom());
      case (ph)
        0: plen = 1;
        1: plen = 2;
        2: plen = 16;
        default: plen = $urandom_range(1, 16);
      endcase
      rlen = (ph == 3) ? 16 : $urandom_range(0, 16);
      foreach (p[i]) p[i] = alpha[$urandom_range(0, 2)];
      foreach (r[i]) r[i] = 8'($urandom());
      program_regs(p, plen, r, rlen);
      n = $urandom_range(12, 18);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 30) begin
          // copy a run of the pattern itself
          for (int j = 0; j < plen && i < n; j++, i++)
            send_byte(p[j], (i == n - 1) || ($urandom_range(0, 99) < 2));
          i--;
        end else begin
          b = ($urandom_range(0, 99) < 75) ? alpha[$urandom_range(0, 2)] : 8'($urandom());
          send_byte(b, (i == n - 1) || ($urandom_range(0, 99) < 4));
        end
      end
    end

    drain();
    $display("covered %0d input bytes, %0d results over %0d configurations",
             sb.items_seen, sb.results_seen, phase_count + 1);
    $display("patterns of 1 to 16 bytes, replacements of 0 to 16, with fallback and flush");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
